### rtl/baf_pkg.sv
// ----------------------------------------------------------------------------
// baf_pkg
// Types and constants shared by the Bezier flattener.
// ----------------------------------------------------------------------------
package baf_pkg;

  localparam int CoordW = 24;
  localparam int ThrW   = 44;
  localparam int RefW   = 16;
  localparam int SegW   = 14;
  localparam int TagW   = 64;
  localparam int CfgW   = 44;
  localparam logic [ThrW-1:0] DefaultThr = 44'd3277;

  localparam logic CfgIdxThr = 1'b0;
  localparam logic CfgIdxRef = 1'b1;

  typedef struct packed {
    logic              is_quadratic;
    logic [CoordW-1:0] p0_x;
    logic [CoordW-1:0] p0_y;
    logic [CoordW-1:0] p1_x;
    logic [CoordW-1:0] p1_y;
    logic [CoordW-1:0] p2_x;
    logic [CoordW-1:0] p2_y;
    logic [CoordW-1:0] p3_x;
    logic [CoordW-1:0] p3_y;
    logic [SegW-1:0]   segment_number;
    logic              emit_start;
  } baf_in_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [TagW-1:0]   point_tag;
    logic              last_point;
  } baf_out_t;

endpackage

### rtl/bezier_adaptive_flattener_top.sv
// ----------------------------------------------------------------------------
// bezier_adaptive_flattener_top
// Adaptive De Casteljau flattening of one cubic or quadratic Bezier segment.
// ----------------------------------------------------------------------------
// One segment is taken at a time. The sequencer visits the tree nodes in
// order: a node that is split keeps its left half in registers and pushes
// its right half to a stack memory. A leaf takes three steps: visit, emit,
// and a pop that takes the next right half from the memory through a
// registered read. The last leaf has no pop. A segment also spends time
// taking the item, on the start point when it is asked for, and on every
// wait of a point on the output. Splitting stops at a depth cap of 5.
module bezier_adaptive_flattener_top
  import baf_pkg::*;
#(
  parameter int MAX_DEPTH = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  baf_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output baf_out_t        out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  localparam int FRAC = 3 * MAX_DEPTH;
  localparam int CW   = CoordW + FRAC;
  localparam int DW   = (MAX_DEPTH < 2) ? 1 : $clog2(MAX_DEPTH);
  localparam int SW   = $clog2(MAX_DEPTH + 1);
  localparam int IW   = MAX_DEPTH + 1;
  localparam int SUMW = CW + 5;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_NODE  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_POP   = 5'b10000
  } state_t;

  typedef logic signed [CW-1:0] crd_t;

  state_t             state_r, state_nxt;
  logic [ThrW-1:0]    thr_r;
  logic [RefW-1:0]    ref_r;
  crd_t               c_r [8];
  crd_t               c_nxt [8];
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [SW-1:0]      sp_r, sp_nxt;
  logic               quad_r;
  logic [SegW-1:0]    seg_r;
  baf_out_t           out_r;
  logic               out_v_r;

  logic [8*CW-1:0]    cmem [MAX_DEPTH];
  logic [IW-1:0]      imem [MAX_DEPTH];
  logic [8*CW-1:0]    crd_rd_r;
  logic [IW-1:0]      idx_rd_r;
  logic               push;
  logic [DW-1:0]      wptr, rptr;
  logic [8*CW-1:0]    push_data;

  crd_t               l [8];
  crd_t               r [8];
  logic [SUMW-1:0]    sum;
  logic [SUMW+16-1:0] sum_s, thr_s;
  logic               flat, leaf;
  logic [ThrW-1:0]    thr_eff;

  function automatic crd_t midp(crd_t a, crd_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] && s[0]) s = s + 1'b1;
    return s[CW:1];
  endfunction

  function automatic logic [SUMW-1:0] d2abs(crd_t a, crd_t b, crd_t c);
    logic signed [CW+2:0] v;
    v = {{3{a[CW-1]}}, a} + {{3{c[CW-1]}}, c} - ({{3{b[CW-1]}}, b} <<< 1);
    if (v[CW+2]) v = -v;
    return SUMW'(v);
  endfunction

  function automatic logic [CoordW-1:0] rnd(crd_t v);
    logic [CW-1:0] m;
    logic [CW-1:0] q;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    q = (m + (CW'(1) << (FRAC - 1))) >> FRAC;
    if (v[CW-1]) q = -q;
    return q[CoordW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      crd_t a, b, d, ab, bd, m;
      a = midp(c_r[k], c_r[2+k]);
      b = midp(c_r[2+k], c_r[4+k]);
      d = midp(c_r[4+k], c_r[6+k]);
      ab = midp(a, b);
      bd = midp(b, d);
      if (quad_r) begin
        m = ab;
        l[k] = c_r[k]; l[2+k] = a; l[4+k] = m; l[6+k] = '0;
        r[k] = m; r[2+k] = b; r[4+k] = c_r[4+k]; r[6+k] = '0;
      end else begin
        m = midp(ab, bd);
        l[k] = c_r[k]; l[2+k] = a; l[4+k] = ab; l[6+k] = m;
        r[k] = m; r[2+k] = bd; r[4+k] = d; r[6+k] = c_r[6+k];
      end
    end
  end

  always_comb begin
    sum = d2abs(c_r[0], c_r[2], c_r[4]) + d2abs(c_r[1], c_r[3], c_r[5]);
    if (!quad_r)
      sum = sum + d2abs(c_r[2], c_r[4], c_r[6]) + d2abs(c_r[3], c_r[5], c_r[7]);
    thr_eff = (thr_r == '0) ? DefaultThr : thr_r;
    sum_s = (SUMW + 16)'(sum) << 15;
    thr_s = (SUMW + 16)'(thr_eff) << FRAC;
    flat = sum_s < thr_s;
    leaf = flat || idx_r[IW-1];
  end

  assign wptr = sp_r[DW-1:0];
  assign rptr = DW'(sp_r - 1'b1);
  always_comb begin
    for (int i = 0; i < 8; i++) push_data[i*CW +: CW] = r[i];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmem[wptr] <= push_data;
      imem[wptr] <= {idx_r[IW-2:0], 1'b1};
    end
    crd_rd_r <= cmem[rptr];
    idx_rd_r <= imem[rptr];
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sp_nxt    = sp_r;
    push      = 1'b0;
    for (int i = 0; i < 8; i++) c_nxt[i] = c_r[i];
    unique case (state_r)
      ST_IDLE: begin
        c_nxt[0] = crd_t'({in_data.p0_x, FRAC'(0)});
        c_nxt[1] = crd_t'({in_data.p0_y, FRAC'(0)});
        c_nxt[2] = crd_t'({in_data.p1_x, FRAC'(0)});
        c_nxt[3] = crd_t'({in_data.p1_y, FRAC'(0)});
        c_nxt[4] = crd_t'({in_data.p2_x, FRAC'(0)});
        c_nxt[5] = crd_t'({in_data.p2_y, FRAC'(0)});
        c_nxt[6] = crd_t'({in_data.p3_x, FRAC'(0)});
        c_nxt[7] = crd_t'({in_data.p3_y, FRAC'(0)});
        idx_nxt  = IW'(1);
        if (in_valid) state_nxt = in_data.emit_start ? ST_START : ST_NODE;
      end
      ST_START: begin
        if (!out_v_r || out_ready) state_nxt = ST_NODE;
      end
      ST_NODE: begin
        if (leaf) begin
          if (!out_v_r || out_ready) state_nxt = ST_EMIT;
        end else begin
          push = 1'b1;
          sp_nxt = sp_r + 1'b1;
          for (int i = 0; i < 8; i++) c_nxt[i] = l[i];
          idx_nxt = {idx_r[IW-2:0], 1'b0};
        end
      end
      ST_EMIT: begin
        if (sp_r == '0) state_nxt = ST_IDLE;
        else state_nxt = ST_POP;
      end
      ST_POP: begin
        for (int i = 0; i < 8; i++) c_nxt[i] = crd_rd_r[i*CW +: CW];
        idx_nxt = idx_rd_r;
        sp_nxt = sp_r - 1'b1;
        state_nxt = ST_NODE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
      thr_r   <= DefaultThr;
      ref_r   <= '0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      if (cfg_we && cfg_index == CfgIdxThr) thr_r <= cfg_wdata[ThrW-1:0];
      if (cfg_we && cfg_index == CfgIdxRef) ref_r <= cfg_wdata[RefW-1:0];
      if (((state_r == ST_START) || ((state_r == ST_NODE) && leaf)) &&
          (!out_v_r || out_ready))
        out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    for (int i = 0; i < 8; i++) c_r[i] <= c_nxt[i];
    if (state_r == ST_IDLE) begin
      quad_r <= in_data.is_quadratic;
      seg_r  <= in_data.segment_number;
    end
    if ((state_r == ST_START) && (!out_v_r || out_ready)) begin
      out_r.point_x    <= rnd(c_r[0]);
      out_r.point_y    <= rnd(c_r[1]);
      out_r.point_tag  <= {1'b0, quad_r, seg_r, ref_r, 32'd1};
      out_r.last_point <= 1'b0;
    end
    if ((state_r == ST_NODE) && leaf && (!out_v_r || out_ready)) begin
      out_r.point_x    <= quad_r ? rnd(c_r[4]) : rnd(c_r[6]);
      out_r.point_y    <= quad_r ? rnd(c_r[5]) : rnd(c_r[7]);
      out_r.point_tag  <= {1'b0, quad_r, seg_r, ref_r, 32'(idx_r)};
      out_r.last_point <= (sp_r == '0);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
